/* rtl/abtw_pkg.sv */
package abtw_pkg;

	localparam int CAPACITY = 63;
	localparam int STACK_DEPTH = 6;

	typedef enum logic [1:0] {
		CMD_PUSH     = 2'd0,
		CMD_TRAVERSE = 2'd1,
		CMD_SEARCH   = 2'd2,
		CMD_NONE     = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ORD_PRE  = 2'd0,
		ORD_IN   = 2'd1,
		ORD_POST = 2'd2,
		ORD_RSVD = 2'd3
	} order_t;

	typedef struct packed {
		logic [1:0]        cmd;
		logic signed [31:0] value;
		logic [5:0]        start_index;
	} req_t;

	typedef struct packed {
		logic signed [31:0] node_value;
		logic [5:0]        position;
		logic              found;
		logic [2:0]        depth;
		logic              last;
	} rsp_t;

	// floor(log2(idx+1)) for a 6-bit index
	function automatic logic [2:0] level_of(input logic [5:0] idx);
		logic [6:0] n;
		logic [2:0] d;
		n = {1'b0, idx} + 7'd1;
		d = 3'd0;
		for (int b = 1; b < 7; b++) begin
			if (n[b]) d = 3'(b);
		end
		return d;
	endfunction

endpackage

/* rtl/array_binary_tree_walker.sv */
// channel  | direction | handshake            | payload
// req      | in        | req_valid, req_stall | req_t (cmd, value, start_index)
// rsp      | out       | rsp_valid, rsp_stall | rsp_t (node_value, position, found, depth, last)
// cfg      | in        | cfg_we               | cfg_wdata (traversal order)
//
// a push, an ignored request or an empty traverse gives no result
// search: each entry compared passes S_SRCH_RD (read) and S_SRCH_CMP (compare); a miss ends in S_SRCH_MISS
// traverse: per subtree node, three stack steps (S_WALK) and one value capture (S_EMIT); then S_FLUSH
// the node store has no reset; node_count, the order register and control clear on arst_n
// a result waiting in the output register stalls the walk; req_stall is high until it ends
module array_binary_tree_walker import abtw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  req_t        req,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output rsp_t        rsp,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_wdata
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SRCH_RD,   // issue read of entry idx_q, or give up past the count
		S_SRCH_CMP,  // entry data back, compare with the key
		S_SRCH_MISS, // send the not-found result
		S_WALK,      // one stack step of the traversal
		S_EMIT,      // node value back, capture into the held result
		S_FLUSH      // send the held result with last set
	} state_t;

	// where a stack frame stands in its node
	typedef enum logic [1:0] {
		PH_ENTER,    // just entered
		PH_LEFT,     // left subtree done
		PH_RIGHT     // right subtree done
	} phase_t;

	// node store, registered read
	logic signed [31:0] mem [CAPACITY];
	logic        mem_we;
	logic [5:0]  mem_waddr;
	logic [5:0]  mem_raddr;
	logic        mem_re;
	logic signed [31:0] rdata_q;

	state_t      state_q;
	logic [5:0]  count_q;
	logic [1:0]  order_q;
	order_t      ord_q;          // order latched for the running walk
	logic [5:0]  idx_q;          // search index
	logic signed [31:0] key_q;
	logic [5:0]  emit_idx_q;     // node whose value is being read
	logic        any_q;          // a traversal result is being held back
	rsp_t        hold_q;         // held result, sent once the next one is known
	// walk stack: node index and phase per level
	logic [5:0]  stk_idx_q [STACK_DEPTH];
	phase_t      stk_ph_q  [STACK_DEPTH];
	logic [2:0]  sp_q;

	logic        out_free;
	logic        out_load;
	rsp_t        out_data;
	logic [2:0]  top_ptr;
	logic [5:0]  top_idx;
	phase_t      top_ph;
	logic        emit_now;
	logic [6:0]  lc, rc;

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= req.value;
		if (mem_re) rdata_q <= mem[mem_raddr];
	end

	assign out_free  = !rsp_valid || !rsp_stall;
	assign req_stall = (state_q != S_IDLE);

	// top of the walk stack, only looked at while the stack holds a frame
	assign top_ptr = sp_q - 3'd1;
	assign top_idx = stk_idx_q[top_ptr];
	assign top_ph  = stk_ph_q[top_ptr];
	assign lc = {top_idx, 1'b1};
	assign rc = {top_idx, 1'b0} + 7'd2;

	// the node is emitted at the phase that matches the order
	always_comb begin
		emit_now = 1'b0;
		case (top_ph)
			PH_ENTER: emit_now = (ord_q == ORD_PRE);
			PH_LEFT:  emit_now = (ord_q == ORD_IN);
			default:  emit_now = (ord_q == ORD_POST);
		endcase
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = count_q;
		mem_re    = 1'b0;
		mem_raddr = idx_q;
		if (state_q == S_IDLE && req_valid && req.cmd == CMD_PUSH && count_q < 6'(CAPACITY))
			mem_we = 1'b1;
		if (state_q == S_SRCH_RD && idx_q < count_q) begin
			mem_re = 1'b1;
		end else if (state_q == S_WALK && sp_q != 3'd0 && emit_now) begin
			mem_re    = 1'b1;
			mem_raddr = top_idx;
		end
	end

	// result going into the output register this cycle
	always_comb begin
		out_load = 1'b0;
		out_data = '0;
		unique case (state_q)
			S_SRCH_CMP: begin
				if (rdata_q == key_q) begin
					out_load = out_free;
					out_data = '{node_value: rdata_q, position: idx_q, found: 1'b1,
						depth: level_of(idx_q), last: 1'b1};
				end
			end
			S_SRCH_MISS: begin
				out_load = out_free;
				out_data = '{node_value: '0, position: '0, found: 1'b0,
					depth: '0, last: 1'b1};
			end
			S_EMIT: begin
				out_load = out_free && any_q;
				out_data = hold_q;
			end
			S_FLUSH: begin
				out_load = out_free;
				out_data = hold_q;
				out_data.last = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			order_q    <= '0;
			ord_q      <= ORD_PRE;
			idx_q      <= '0;
			key_q      <= '0;
			emit_idx_q <= '0;
			any_q      <= 1'b0;
			hold_q     <= '0;
			sp_q       <= '0;
			rsp_valid  <= 1'b0;
			rsp        <= '0;
			for (int k = 0; k < STACK_DEPTH; k++) begin
				stk_idx_q[k] <= '0;
				stk_ph_q[k]  <= PH_ENTER;
			end
		end else begin
			if (cfg_we) order_q <= cfg_wdata;
			// output register: load a new result or drop the one just taken
			if (out_load) begin
				rsp_valid <= 1'b1;
				rsp       <= out_data;
			end else if (rsp_valid && !rsp_stall) begin
				rsp_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						case (cmd_t'(req.cmd))
							CMD_PUSH: begin
								if (count_q < 6'(CAPACITY)) count_q <= count_q + 6'd1;
							end
							CMD_SEARCH: begin
								idx_q   <= '0;
								key_q   <= req.value;
								state_q <= S_SRCH_RD;
							end
							CMD_TRAVERSE: begin
								// a start at or beyond the count gives nothing
								if (req.start_index < count_q) begin
									stk_idx_q[0] <= req.start_index;
									stk_ph_q[0]  <= PH_ENTER;
									sp_q         <= 3'd1;
									ord_q   <= (order_q == ORD_RSVD) ? ORD_PRE : order_t'(order_q);
									any_q   <= 1'b0;
									state_q <= S_WALK;
								end
							end
							default: ;
						endcase
					end
				end
				S_SRCH_RD: begin
					state_q <= (idx_q < count_q) ? S_SRCH_CMP : S_SRCH_MISS;
				end
				S_SRCH_CMP: begin
					// rdata_q holds entry idx_q until the next read
					if (rdata_q == key_q) begin
						if (out_free) state_q <= S_IDLE;
					end else begin
						idx_q   <= idx_q + 6'd1;
						state_q <= S_SRCH_RD;
					end
				end
				S_SRCH_MISS: begin
					if (out_free) state_q <= S_IDLE;
				end
				S_WALK: begin
					if (sp_q == 3'd0) begin
						state_q <= S_FLUSH;
					end else begin
						if (emit_now) begin
							emit_idx_q <= top_idx;
							state_q    <= S_EMIT;
						end
						case (top_ph)
							PH_ENTER: begin
								stk_ph_q[top_ptr] <= PH_LEFT;
								if (lc < {1'b0, count_q}) begin
									stk_idx_q[sp_q] <= lc[5:0];
									stk_ph_q[sp_q]  <= PH_ENTER;
									sp_q <= sp_q + 3'd1;
								end
							end
							PH_LEFT: begin
								stk_ph_q[top_ptr] <= PH_RIGHT;
								if (rc < {1'b0, count_q}) begin
									stk_idx_q[sp_q] <= rc[5:0];
									stk_ph_q[sp_q]  <= PH_ENTER;
									sp_q <= sp_q + 3'd1;
								end
							end
							default: sp_q <= sp_q - 3'd1;
						endcase
					end
				end
				S_EMIT: begin
					// the held result leaves first, so it needs a free output
					if (out_free || !any_q) begin
						hold_q <= '{node_value: rdata_q, position: emit_idx_q, found: 1'b1,
							depth: level_of(emit_idx_q), last: 1'b0};
						any_q   <= 1'b1;
						state_q <= S_WALK;
					end
				end
				S_FLUSH: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
		else $error("stalled response changed");
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 6'(CAPACITY)) else $error("count overflow");
	a_sp_range: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= 3'(STACK_DEPTH)) else $error("stack overflow");
`endif

endmodule
